>>> sv/hdj_pkg.sv
package hdj_pkg;

  // field widths of the block's ports
  localparam int VAL_W  = 24;
  localparam int IDX_W  = 6;
  localparam int PASS_W = 20;

  // pass counter stops here
  localparam logic [PASS_W-1:0] PASS_MAX = {PASS_W{1'b1}};

  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [PASS_W-1:0] pass_t;

endpackage

>>> sv/hdj_ram.sv
module hdj_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/hdj_stencil.sv
module hdj_stencil (
  input  hdj_pkg::val_t left_val,
  input  hdj_pkg::val_t centre_val,
  input  hdj_pkg::val_t right_val,
  input  hdj_pkg::val_t epsilon,
  output hdj_pkg::val_t new_val,
  output logic          unstable
);

  import hdj_pkg::*;

  logic [VAL_W+1:0] sum;
  val_t             diff;

  // (left + 2*centre + right) / 4, truncated
  assign sum     = {2'b00, left_val} + {1'b0, centre_val, 1'b0} + {2'b00, right_val};
  assign new_val = sum[VAL_W+1:2];

  // absolute change against the old centre value
  assign diff     = (centre_val > new_val) ? (centre_val - new_val) : (new_val - centre_val);
  assign unstable = diff > epsilon;

endmodule

>>> sv/heat_diffusion_jacobi_1d_unit.sv
// One-dimensional heat diffusion by Jacobi relaxation. Samples (unsigned Q8.16)
// are taken one per cycle until the transaction marked last; samples beyond
// ROD_LENGTH are dropped, though a last mark still starts the relaxation. Each
// pass replaces every interior cell by (left + 2*centre + right)/4 and keeps
// both end cells; passes repeat until no interior cell moved by more than
// epsilon, or until the pass count reaches its 20-bit maximum. At least one
// pass always runs. Then every cell leaves as one transaction with its index,
// a final-cell flag and the pass count. A pass is paced by the single read
// port of the grid RAM feeding one shared stencil unit one cell per cycle
// (each cell read in turn, the registered read data, then one write of the
// far end cell); when emitting, each cell goes through a registered RAM read
// before the output register, and the next cell is loaded into it only once
// the current one has been taken. The input side is not ready from the last
// sample until the final cell has been taken. epsilon may only be written
// while the block is idle.
module heat_diffusion_jacobi_1d_unit #(
  parameter int ROD_LENGTH    = 64,
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  hdj_pkg::val_t         cfg_wdata,
  // sample input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hdj_pkg::val_t         in_sample_value,
  input  logic                  in_last_sample,
  // cell output
  output logic                  out_valid,
  input  logic                  out_ready,
  output hdj_pkg::val_t         out_cell_value,
  output hdj_pkg::idx_t         out_cell_index,
  output logic                  out_final_cell,
  output hdj_pkg::pass_t        out_pass_count
);

  import hdj_pkg::*;

  localparam int AW = $clog2(ROD_LENGTH);
  localparam int CW = $clog2(ROD_LENGTH + 1);
  // 0.1 in the chosen fixed-point format, rounded
  localparam val_t EPS_RESET = VAL_W'(((32'd1 << FRACTION_BITS) + 32'd5) / 32'd10);

  typedef enum logic [4:0] {
    S_LOAD     = 5'b00001,
    S_PASS     = 5'b00010,
    S_EMIT_RD  = 5'b00100,
    S_EMIT_LD  = 5'b01000,
    S_EMIT_OUT = 5'b10000
  } state_t;

  state_t          state_r, state_nxt;
  val_t            eps_r;
  logic [CW-1:0]   cnt_r, cnt_nxt;       // cells held
  logic            cur_bank_r, cur_bank_nxt; // bank holding the current grid
  pass_t           pass_r, pass_nxt;
  logic            stable_r, stable_nxt;
  logic [AW-1:0]   rd_idx_r, rd_idx_nxt;
  logic            rd_act_r, rd_act_nxt;
  logic            dv_r, dv_nxt;         // read data valid this cycle
  logic [AW-1:0]   dj_r, dj_nxt;         // index of the read data
  logic            tail_r, tail_nxt;     // far end cell write pending
  logic [AW-1:0]   k_r, k_nxt;           // emit index
  logic            out_valid_r, out_valid_nxt;

  // window and output payload
  val_t            wl_r, wc_r;
  val_t            out_value_r;
  idx_t            out_index_r;
  logic            out_final_r;

  // grid ram ports
  logic            wr_en, wr_bank;
  logic [AW-1:0]   wr_addr, rd_addr;
  val_t            wr_data;
  val_t            rdata0, rdata1, rdata;

  logic [CW-1:0]   len_m1;
  logic [AW-1:0]   last_idx;
  logic            in_acc, out_acc, room;
  val_t            st_new;
  logic            st_unstable;
  pass_t           pass_inc;

  assign len_m1   = cnt_r - CW'(1);
  assign last_idx = len_m1[AW-1:0];
  assign in_ready = (state_r == S_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid_r && out_ready;
  assign room     = cnt_r < CW'(ROD_LENGTH);
  assign rdata    = cur_bank_r ? rdata1 : rdata0;
  // saturating pass count
  assign pass_inc = (pass_r == PASS_MAX) ? pass_r : pass_r + PASS_W'(1);

  assign out_valid      = out_valid_r;
  assign out_cell_value = out_value_r;
  assign out_cell_index = out_index_r;
  assign out_final_cell = out_final_r;
  assign out_pass_count = pass_r;

  // the one stencil unit: left, centre from the window, right straight off the ram
  hdj_stencil u_stencil (
    .left_val   (wl_r),
    .centre_val (wc_r),
    .right_val  (rdata),
    .epsilon    (eps_r),
    .new_val    (st_new),
    .unstable   (st_unstable)
  );

  // ping-pong grid banks
  hdj_ram #(.WIDTH(VAL_W), .DEPTH(ROD_LENGTH)) u_grid0 (
    .clk   (clk),
    .we    (wr_en && !wr_bank),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rdata0)
  );

  hdj_ram #(.WIDTH(VAL_W), .DEPTH(ROD_LENGTH)) u_grid1 (
    .clk   (clk),
    .we    (wr_en && wr_bank),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rdata1)
  );

  // ram address and write selection
  always_comb begin
    wr_en   = 1'b0;
    wr_bank = ~cur_bank_r;
    wr_addr = '0;
    wr_data = rdata;
    rd_addr = '0;
    unique case (state_r)
      S_LOAD: begin
        // samples go straight into the current bank
        wr_en   = in_acc && room;
        wr_bank = cur_bank_r;
        wr_addr = cnt_r[AW-1:0];
        wr_data = in_sample_value;
      end
      S_PASS: begin
        rd_addr = rd_idx_r;
        if (tail_r) begin
          // far end cell carried over unchanged
          wr_en   = 1'b1;
          wr_addr = last_idx;
          wr_data = wc_r;
        end else if (dv_r && (dj_r == '0)) begin
          // near end cell carried over unchanged
          wr_en   = 1'b1;
          wr_addr = '0;
          wr_data = rdata;
        end else if (dv_r && (dj_r >= AW'(2))) begin
          wr_en   = 1'b1;
          wr_addr = dj_r - AW'(1);
          wr_data = st_new;
        end
      end
      S_EMIT_RD:  rd_addr = k_r;
      S_EMIT_LD:  rd_addr = k_r;
      S_EMIT_OUT: rd_addr = k_r + AW'(1);
      default:    rd_addr = '0;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cur_bank_nxt  = cur_bank_r;
    pass_nxt      = pass_r;
    stable_nxt    = stable_r;
    rd_idx_nxt    = rd_idx_r;
    rd_act_nxt    = rd_act_r;
    dv_nxt        = 1'b0;
    dj_nxt        = dj_r;
    tail_nxt      = 1'b0;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (room) begin
            cnt_nxt = cnt_r + CW'(1);
          end
          if (in_last_sample) begin
            state_nxt  = S_PASS;
            pass_nxt   = '0;
            rd_idx_nxt = '0;
            rd_act_nxt = 1'b1;
            stable_nxt = 1'b1;
          end
        end
      end
      S_PASS: begin
        // read sweep over the source bank
        if (rd_act_r) begin
          dv_nxt     = 1'b1;
          dj_nxt     = rd_idx_r;
          rd_idx_nxt = rd_idx_r + AW'(1);
          if (rd_idx_r == last_idx) begin
            rd_act_nxt = 1'b0;
          end
        end
        if (dv_r) begin
          if ((dj_r >= AW'(2)) && st_unstable) begin
            stable_nxt = 1'b0;
          end
          tail_nxt = (dj_r == last_idx);
        end
        // end of pass: swap banks and decide whether to go again
        if (tail_r) begin
          pass_nxt     = pass_inc;
          cur_bank_nxt = ~cur_bank_r;
          if (stable_r || (pass_inc == PASS_MAX)) begin
            state_nxt = S_EMIT_RD;
            k_nxt     = '0;
          end else begin
            rd_idx_nxt = '0;
            rd_act_nxt = 1'b1;
            stable_nxt = 1'b1;
          end
        end
      end
      S_EMIT_RD: state_nxt = S_EMIT_LD;
      S_EMIT_LD: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          if (k_r == last_idx) begin
            state_nxt = S_LOAD;
            cnt_nxt   = '0;
          end else begin
            k_nxt     = k_r + AW'(1);
            state_nxt = S_EMIT_LD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      eps_r       <= EPS_RESET;
      cnt_r       <= '0;
      cur_bank_r  <= 1'b0;
      pass_r      <= '0;
      stable_r    <= 1'b1;
      rd_idx_r    <= '0;
      rd_act_r    <= 1'b0;
      dv_r        <= 1'b0;
      dj_r        <= '0;
      tail_r      <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        eps_r <= cfg_wdata;
      end
      cnt_r       <= cnt_nxt;
      cur_bank_r  <= cur_bank_nxt;
      pass_r      <= pass_nxt;
      stable_r    <= stable_nxt;
      rd_idx_r    <= rd_idx_nxt;
      rd_act_r    <= rd_act_nxt;
      dv_r        <= dv_nxt;
      dj_r        <= dj_nxt;
      tail_r      <= tail_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // window shift and output payload, no reset needed
  always_ff @(posedge clk) begin
    if ((state_r == S_PASS) && dv_r) begin
      wl_r <= wc_r;
      wc_r <= rdata;
    end
    if (state_r == S_EMIT_LD) begin
      out_value_r <= rdata;
      out_index_r <= IDX_W'(k_r);
      out_final_r <= (k_r == last_idx);
    end
  end

endmodule

>>> dv/heat_diffusion_jacobi_1d_unit_tb.sv
module heat_diffusion_jacobi_1d_unit_tb;
  import hdj_pkg::*;

  localparam int ROD = 64;
  localparam int FRAC = 16;
  localparam val_t EPS_AT_RESET = val_t'(((1 << FRAC) + 5) / 10);
  localparam int MAX_SAMPLES = 70;
  // relaxation cycles allowed per rod, so that the run stays short
  localparam int SETTLE_BUDGET = 20000;
  // cycles without any transaction before the run is abandoned
  localparam int QUIET_LIMIT = 200000;
  localparam int TARGET_ITEMS = 210;

  typedef enum logic [1:0] {FILL_CONST, FILL_RAMP, FILL_EDGES, FILL_NOISE} fill_t;

  // one directed rod: how it is filled, an optional epsilon write before it,
  // and whether its cells must come back exactly as loaded after one pass
  typedef struct packed {
    int    n;
    fill_t fill;
    val_t  a;
    val_t  b;
    logic  set_eps;
    val_t  eps;
    logic  unchanged;
  } rod_row_t;

  typedef struct {
    val_t  value;
    idx_t  index;
    logic  last;
    pass_t passes;
  } cell_t;

  localparam rod_row_t DIRECTED [8] = '{
    // single cell at full scale: no interior, one pass
    '{1, FILL_CONST, 24'hFFFFFF, 24'h000000, 1'b0, 24'h000000, 1'b1},
    // two cells at both extremes: still no interior
    '{2, FILL_RAMP, 24'h000000, 24'hFFFFFF, 1'b0, 24'h000000, 1'b1},
    // hot centre between cold ends, reset epsilon
    '{3, FILL_EDGES, 24'h000000, 24'hFFFFFF, 1'b0, 24'h000000, 1'b0},
    // cold interior between hot ends, zero epsilon
    '{5, FILL_EDGES, 24'hFFFFFF, 24'h000000, 1'b1, 24'h000000, 1'b0},
    // full-range linear rod, two samples past the end are dropped
    '{66, FILL_RAMP, 24'h000000, 24'h041041, 1'b0, 24'h000000, 1'b1},
    // largest epsilon: settles after a single pass
    '{4, FILL_NOISE, 24'h000000, 24'hFFFFFF, 1'b1, 24'hFFFFFF, 1'b0},
    // tight epsilon on random temperatures
    '{8, FILL_NOISE, 24'h000000, 24'hFFFFFF, 1'b1, 24'h000001, 1'b0},
    // flat cold rod
    '{3, FILL_CONST, 24'h000000, 24'h000000, 1'b0, 24'h000000, 1'b1}
  };

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  cfg_we = 1'b0;
  val_t  cfg_wdata = '0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  val_t  in_sample_value = '0;
  logic  in_last_sample = 1'b0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  val_t  out_cell_value;
  idx_t  out_cell_index;
  logic  out_final_cell;
  pass_t out_pass_count;

  // predictor state
  val_t  loaded_cells [ROD];
  int    n_loaded = 0;
  val_t  eps_now = EPS_AT_RESET;
  val_t  work_grid [ROD];
  cell_t settled_cells [$];
  logic  rod_unchanged = 1'b0;

  // stimulus and bookkeeping
  val_t  rod_plan [MAX_SAMPLES];
  int    burst_left = 0;
  int    items_sent = 0;
  int    mismatches = 0;
  int    quiet_cycles = 0;
  int    stall_left = 0;
  int    stall_mode = 0;
  int    mode_left = 0;

  heat_diffusion_jacobi_1d_unit #(
    .ROD_LENGTH   (ROD),
    .FRACTION_BITS(FRAC)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_value(in_sample_value),
    .in_last_sample (in_last_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_value (out_cell_value),
    .out_cell_index (out_cell_index),
    .out_final_cell (out_final_cell),
    .out_pass_count (out_pass_count)
  );

  always #10 clk = ~clk;

  // jacobi passes over the first n cells of work_grid until every interior
  // cell moved by no more than eps, or until cap passes have run; the left
  // neighbour's old value is kept aside so the update can be done in place
  function automatic pass_t relax_rod(input int n, input val_t eps, input pass_t cap);
    pass_t             passes;
    logic              steady;
    val_t              left, centre, fresh, moved;
    logic [VAL_W+1:0]  total;
    passes = '0;
    do begin
      steady = 1'b1;
      left = work_grid[0];
      for (int i = 1; i + 1 < n; i++) begin
        centre = work_grid[i];
        total = {2'b00, left} + {1'b0, centre, 1'b0} + {2'b00, work_grid[i+1]};
        fresh = total[VAL_W+1:2];
        moved = (centre > fresh) ? centre - fresh : fresh - centre;
        if (moved > eps) steady = 1'b0;
        work_grid[i] = fresh;
        left = centre;
      end
      passes++;
    end while (!steady && passes != cap);
    return passes;
  endfunction

  // one accepted sample: store it while there is room, and on the last one
  // settle the rod and queue every cell as an expected transaction
  function automatic void take_sample(input val_t v, input logic lst);
    pass_t passes;
    if (n_loaded < ROD) begin
      loaded_cells[n_loaded] = v;
      n_loaded++;
    end
    if (lst) begin
      for (int k = 0; k < n_loaded; k++) work_grid[k] = loaded_cells[k];
      // flat and linear rods are known to come back untouched after one pass
      passes = rod_unchanged ? pass_t'(1) : relax_rod(n_loaded, eps_now, PASS_MAX);
      for (int k = 0; k < n_loaded; k++)
        settled_cells.push_back('{work_grid[k], idx_t'(k), (k == n_loaded - 1), passes});
      n_loaded = 0;
    end
  endfunction

  // fill the rod plan; a rod that would relax for too long under the
  // current epsilon is flattened instead
  function automatic void plan_rod(input int n, input fill_t fill, input val_t a,
                                   input val_t b);
    int    held;
    pass_t cap;
    for (int i = 0; i < n; i++) begin
      case (fill)
        FILL_CONST: rod_plan[i] = a;
        FILL_RAMP:  rod_plan[i] = val_t'(a + val_t'(i) * b);
        FILL_EDGES: rod_plan[i] = (i == 0 || i == n - 1) ? a : b;
        default:    rod_plan[i] = val_t'(a + (val_t'($urandom) & b));
      endcase
    end
    held = (n < ROD) ? n : ROD;
    for (int k = 0; k < held; k++) work_grid[k] = rod_plan[k];
    cap = pass_t'(SETTLE_BUDGET / (held + 2));
    if (relax_rod(held, eps_now, cap) == cap)
      for (int i = 0; i < n; i++) rod_plan[i] = a;
  endfunction

  // present one sample after an optional gap and hold it until taken;
  // returns at the accepting edge
  task automatic feed_sample(input val_t v, input logic lst);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
    end
    burst_left--;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_sample_value <= v;
    in_last_sample  <= lst;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_rod(input int n, input logic unchanged);
    rod_unchanged = unchanged;
    for (int i = 0; i < n; i++) feed_sample(rod_plan[i], (i == n - 1));
    items_sent += n;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (settled_cells.size() != 0) @(posedge clk);
  endtask

  // epsilon only changes with the block idle: all cells out, then a short pause
  task automatic write_epsilon(input val_t v);
    wait_drained();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // receiver: moves between always ready, short random stalls and long stalls
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      case (stall_mode)
        1: if ($urandom_range(0, 1) == 0) stall_left = $urandom_range(1, 2);
        2: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(4, 20);
        default: ;
      endcase
    end
    if (mode_left <= 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(16, 200);
    end else begin
      mode_left--;
    end
  end

  // monitor, scoreboard and watchdog, all on the rising edge
  always @(posedge clk) begin
    cell_t want;
    if (!rst_n) begin
      n_loaded = 0;
      eps_now  = EPS_AT_RESET;
    end else begin
      if (cfg_we) eps_now = cfg_wdata;
      if (in_valid && in_ready) take_sample(in_sample_value, in_last_sample);
      if (out_valid && out_ready) begin
        if (settled_cells.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected cell: value %h index %0d final %b passes %0d",
                     out_cell_value, out_cell_index, out_final_cell, out_pass_count);
        end else begin
          want = settled_cells.pop_front();
          if (out_cell_value !== want.value || out_cell_index !== want.index ||
              out_final_cell !== want.last || out_pass_count !== want.passes) begin
            mismatches++;
            if (mismatches <= 10)
              $display("cell mismatch: expected %h/%0d/%b/%0d got %h/%0d/%b/%0d",
                       want.value, want.index, want.last, want.passes,
                       out_cell_value, out_cell_index, out_final_cell, out_pass_count);
          end
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int    n, sel, rods;
    fill_t kind;
    val_t  a, b, eps;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed rods
    for (int r = 0; r < $size(DIRECTED); r++) begin
      if (DIRECTED[r].set_eps) write_epsilon(DIRECTED[r].eps);
      plan_rod(DIRECTED[r].n, DIRECTED[r].fill, DIRECTED[r].a, DIRECTED[r].b);
      send_rod(DIRECTED[r].n, DIRECTED[r].unchanged);
    end

    // random phases: a fresh epsilon, then a handful of rods
    while (items_sent < TARGET_ITEMS) begin
      case ($urandom_range(0, 5))
        0: eps = '0;
        1: eps = val_t'($urandom_range(1, 255));
        2: eps = EPS_AT_RESET;
        3: eps = val_t'($urandom);
        4: eps = '1;
        default: eps = val_t'($urandom_range(256, 65535));
      endcase
      write_epsilon(eps);
      rods = $urandom_range(2, 5);
      repeat (rods) begin
        // mostly short rods, a few long ones and a few that overflow
        sel = $urandom_range(0, 19);
        if (sel == 0) n = $urandom_range(ROD + 1, MAX_SAMPLES);
        else if (sel < 3) n = $urandom_range(13, ROD);
        else n = $urandom_range(1, 12);
        a = val_t'($urandom);
        case ($urandom_range(0, 9))
          0: begin kind = FILL_CONST; b = '0; end
          1: begin kind = FILL_RAMP; b = val_t'($urandom_range(0, 24'h03FFFF)); end
          2: begin kind = FILL_EDGES; b = val_t'($urandom); end
          default: begin
            kind = FILL_NOISE;
            // narrow spread around a random level, or the full range
            case ($urandom_range(0, 2))
              0: b = 24'h0000FF;
              1: b = 24'h000FFF;
              default: b = '1;
            endcase
          end
        endcase
        plan_rod(n, kind, a, b);
        send_rod(n, 1'b0);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

>>> sim.f
sv/hdj_pkg.sv
sv/hdj_ram.sv
sv/hdj_stencil.sv
sv/heat_diffusion_jacobi_1d_unit.sv
dv/heat_diffusion_jacobi_1d_unit_tb.sv
